>>> src/mexp_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the microcode program of the modular exponentiation core.
// No dependencies; every other file in src but mexp_chk imports this package.
package mexp_pkg;

    localparam int FIELD_W   = 32;   // port width of every word field
    localparam int MEXP_WIDTH = 32;  // default operand width
    localparam int PC_W      = 5;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_MUL,      // start the modular multiplier on the selected operands
        OP_WR_ACC,   // accumulator <= multiplier result
        OP_WR_SQ,    // running square <= multiplier result
        OP_SHIFT,    // drop the exponent bit just used
        OP_OUT_ACC,
        OP_OUT_ZERO,
        OP_OUT_ONE
    } t_op;

    typedef enum logic [1:0] {
        SRC_ONE,
        SRC_BASE,
        SRC_ACC,
        SRC_SQ
    } t_src;

    typedef enum logic [2:0] {
        C_NONE,
        C_BASE_Z,
        C_EXP_Z,
        C_MOD_Z,
        C_BIT_CLR,
        C_MORE,
        C_MUL_BUSY
    } t_cond;

    typedef struct packed {
        t_op             op;
        t_src            src_a;
        t_src            src_b;
        t_cond           cond;
        logic [PC_W-1:0] target;
    } t_uword;

    // datapath controls, sequencer -> datapath
    typedef struct packed {
        t_op  op;
        t_src src_a;
        t_src src_b;
    } t_ctrl;

    // jump conditions, datapath -> sequencer
    typedef struct packed {
        logic base_z;
        logic exp_z;
        logic mod_z;
        logic bit_clr;
        logic more;
        logic mul_busy;
    } t_flags;

    localparam logic [PC_W-1:0] L_W_BASE = PC_W'(4);
    localparam logic [PC_W-1:0] L_W_ONE  = PC_W'(7);
    localparam logic [PC_W-1:0] L_LOOP   = PC_W'(9);
    localparam logic [PC_W-1:0] L_W_MUL  = PC_W'(11);
    localparam logic [PC_W-1:0] L_SQR    = PC_W'(13);
    localparam logic [PC_W-1:0] L_W_SQR  = PC_W'(14);
    localparam logic [PC_W-1:0] L_ZERO   = PC_W'(18);
    localparam logic [PC_W-1:0] L_ONE    = PC_W'(19);

    function automatic t_uword rom_word(input logic [PC_W-1:0] pc);
        t_uword w;
        w = '{op: OP_NOP, src_a: SRC_ONE, src_b: SRC_ONE, cond: C_NONE, target: '0};
        unique case (pc)
            PC_W'(0):  begin w.cond = C_BASE_Z;   w.target = L_ZERO;   end
            PC_W'(1):  begin w.cond = C_EXP_Z;    w.target = L_ONE;    end
            PC_W'(2):  begin w.cond = C_MOD_Z;    w.target = L_ZERO;   end
            // sq = base mod m
            PC_W'(3):  begin w.op = OP_MUL; w.src_a = SRC_BASE; end
            PC_W'(4):  begin w.cond = C_MUL_BUSY; w.target = L_W_BASE; end
            PC_W'(5):  w.op = OP_WR_SQ;
            // acc = 1 mod m
            PC_W'(6):  w.op = OP_MUL;
            PC_W'(7):  begin w.cond = C_MUL_BUSY; w.target = L_W_ONE;  end
            PC_W'(8):  w.op = OP_WR_ACC;
            PC_W'(9):  begin w.cond = C_BIT_CLR;  w.target = L_SQR;    end
            PC_W'(10): begin w.op = OP_MUL; w.src_a = SRC_ACC; w.src_b = SRC_SQ; end
            PC_W'(11): begin w.cond = C_MUL_BUSY; w.target = L_W_MUL;  end
            PC_W'(12): w.op = OP_WR_ACC;
            PC_W'(13): begin w.op = OP_MUL; w.src_a = SRC_SQ; w.src_b = SRC_SQ; end
            PC_W'(14): begin w.cond = C_MUL_BUSY; w.target = L_W_SQR;  end
            PC_W'(15): w.op = OP_WR_SQ;
            // stop as soon as no set exponent bit remains
            PC_W'(16): begin w.op = OP_SHIFT; w.cond = C_MORE; w.target = L_LOOP; end
            PC_W'(17): w.op = OP_OUT_ACC;
            PC_W'(18): w.op = OP_OUT_ZERO;
            PC_W'(19): w.op = OP_OUT_ONE;
            default:   w.op = OP_OUT_ZERO;
        endcase
        return w;
    endfunction

endpackage

>>> src/mexp_modmul.sv
`timescale 1ns / 1ps
// Modular multiplier: one registered multiply, then restoring reduction of the
// low product half, one bit per cycle. Needs a, b < m. Depends on mexp_pkg.
module mexp_modmul #(
    parameter int WIDTH = mexp_pkg::MEXP_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    input  logic [WIDTH-1:0] i_m,
    output logic             o_busy,
    output logic [WIDTH-1:0] o_res
);
    import mexp_pkg::*;

    localparam int CW = $clog2(WIDTH + 1);

    logic [2*WIDTH-1:0] prod;
    logic [WIDTH:0]     trial;
    logic [WIDTH:0]     diff;
    logic               ge;

    logic               r_busy;
    logic [CW-1:0]      r_cnt;
    logic [WIDTH-1:0]   r_rem;
    logic [WIDTH-1:0]   r_low;
    logic [WIDTH-1:0]   r_m;

    assign prod  = i_a * i_b;
    assign trial = {r_rem, r_low[WIDTH-1]};
    assign ge    = trial >= {1'b0, r_m};
    assign diff  = trial - {1'b0, r_m};

    // high half of a*b is already below m since a, b < m
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(WIDTH);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= r_cnt != CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= prod[2*WIDTH-1:WIDTH];
            r_low <= prod[WIDTH-1:0];
            r_m   <= i_m;
        end else if (r_busy) begin
            r_rem <= ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
            r_low <= {r_low[WIDTH-2:0], 1'b0};
        end
    end

    assign o_busy = r_busy;
    assign o_res  = r_rem;

endmodule

>>> src/mexp_sequencer.sv
`timescale 1ns / 1ps
// Microcode sequencer: step counter over the program ROM in mexp_pkg, with
// conditional jumps on datapath flags. Depends on mexp_pkg.
module mexp_sequencer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_go,
    input  mexp_pkg::t_flags i_flags,
    output mexp_pkg::t_ctrl  o_ctrl,
    output logic             o_run
);
    import mexp_pkg::*;

    typedef enum logic {ST_IDLE, ST_RUN} t_state;

    t_state          r_state;
    logic [PC_W-1:0] r_pc;
    t_uword          w;
    logic            take;

    always_comb begin
        w = rom_word(r_pc);
        unique case (w.cond)
            C_NONE:     take = 1'b0;
            C_BASE_Z:   take = i_flags.base_z;
            C_EXP_Z:    take = i_flags.exp_z;
            C_MOD_Z:    take = i_flags.mod_z;
            C_BIT_CLR:  take = i_flags.bit_clr;
            C_MORE:     take = i_flags.more;
            C_MUL_BUSY: take = i_flags.mul_busy;
            default:    take = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pc    <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_go) begin
                        r_state <= ST_RUN;
                        r_pc    <= '0;
                    end
                end
                ST_RUN: begin
                    if (w.op inside {OP_OUT_ACC, OP_OUT_ZERO, OP_OUT_ONE})
                        r_state <= ST_IDLE;
                    r_pc <= take ? w.target : r_pc + 1'b1;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_run        = r_state == ST_RUN;
    assign o_ctrl.op    = o_run ? w.op : OP_NOP;
    assign o_ctrl.src_a = w.src_a;
    assign o_ctrl.src_b = w.src_b;

endmodule

>>> src/modular_exponentiation_core.sv
`timescale 1ns / 1ps
// Modular exponentiation core: base^exponent mod modulus by square-and-multiply.
// Depends on mexp_pkg, mexp_sequencer and mexp_modmul.
//
// Usage:
//   Drive i_base, i_exponent, i_modulus and raise start; the word is taken at
//   the edge where start is high and busy is low. busy stays high until the
//   result is out. The result appears on o_result for one cycle with o_valid
//   high; busy drops at the same edge, so the next word may be taken while
//   o_valid is still high. There is no backpressure on the result side.
//   Only the low WIDTH bits of each operand are used.
//   Special cases: base 0 gives 0, else exponent 0 gives 1, else modulus 0 gives 0.
// Datapath: every modular multiply runs on the single shared multiply/restoring-reduce
//   unit. One word is worked on at a time.
// Reset: synchronous, active low; drops busy and o_valid, any word in work is lost.
module modular_exponentiation_core #(
    parameter int WIDTH = mexp_pkg::MEXP_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    input  logic [mexp_pkg::FIELD_W-1:0] i_base,
    input  logic [mexp_pkg::FIELD_W-1:0] i_exponent,
    input  logic [mexp_pkg::FIELD_W-1:0] i_modulus,
    output logic                         busy,
    output logic                         o_valid,
    output logic [mexp_pkg::FIELD_W-1:0] o_result
);
    import mexp_pkg::*;

    t_ctrl            ctrl;
    t_flags           flags;
    logic             run;
    logic             accept;
    logic             mul_busy;
    logic [WIDTH-1:0] mul_res;
    logic [WIDTH-1:0] opnd_a;
    logic [WIDTH-1:0] opnd_b;

    logic [WIDTH-1:0] r_base;
    logic [WIDTH-1:0] r_exp;
    logic [WIDTH-1:0] r_mod;
    logic [WIDTH-1:0] r_acc;
    logic [WIDTH-1:0] r_sq;
    logic [WIDTH-1:0] r_result;
    logic             r_valid;

    function automatic logic [WIDTH-1:0] sel_opnd(input t_src s, input logic [WIDTH-1:0] base,
                                                  input logic [WIDTH-1:0] acc,
                                                  input logic [WIDTH-1:0] sq);
        logic [WIDTH-1:0] v;
        case (s)
            SRC_BASE: v = base;
            SRC_ACC:  v = acc;
            SRC_SQ:   v = sq;
            default:  v = WIDTH'(1);
        endcase
        return v;
    endfunction

    assign accept = start && !run;
    assign opnd_a = sel_opnd(ctrl.src_a, r_base, r_acc, r_sq);
    assign opnd_b = sel_opnd(ctrl.src_b, r_base, r_acc, r_sq);

    assign flags.base_z   = r_base == '0;
    assign flags.exp_z    = r_exp == '0;
    assign flags.mod_z    = r_mod == '0;
    assign flags.bit_clr  = !r_exp[0];
    assign flags.more     = r_exp[WIDTH-1:1] != '0;
    assign flags.mul_busy = mul_busy;

    mexp_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (accept),
        .i_flags (flags),
        .o_ctrl  (ctrl),
        .o_run   (run)
    );

    mexp_modmul #(.WIDTH(WIDTH)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (ctrl.op == OP_MUL),
        .i_a     (opnd_a),
        .i_b     (opnd_b),
        .i_m     (r_mod),
        .o_busy  (mul_busy),
        .o_res   (mul_res)
    );

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_base <= i_base[WIDTH-1:0];
            r_exp  <= i_exponent[WIDTH-1:0];
            r_mod  <= i_modulus[WIDTH-1:0];
        end else if (ctrl.op == OP_SHIFT) begin
            r_exp  <= r_exp >> 1;
        end
        if (ctrl.op == OP_WR_ACC) r_acc <= mul_res;
        if (ctrl.op == OP_WR_SQ)  r_sq  <= mul_res;
        case (ctrl.op)
            OP_OUT_ACC:  r_result <= r_acc;
            OP_OUT_ZERO: r_result <= '0;
            OP_OUT_ONE:  r_result <= WIDTH'(1);
            default:     r_result <= r_result;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= ctrl.op inside {OP_OUT_ACC, OP_OUT_ZERO, OP_OUT_ONE};
        end
    end

    assign busy     = run;
    assign o_valid  = r_valid;
    assign o_result = FIELD_W'(r_result);

endmodule

>>> src/mexp_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the modular exponentiation core, bound to the top level.
// Depends on modular_exponentiation_core port names only.
module mexp_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid
);

    // a taken word keeps the core busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("core not busy after taking a word");

    // o_valid is never high back to back
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    // finishing a word always shows a result
    a_done_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("busy dropped without a result");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while still busy");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_valid)
        else $error("core not idle after reset");

endmodule

bind modular_exponentiation_core mexp_chk u_mexp_chk (.*);

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for modular_exponentiation_core: directed corners, then random words.
// Depends on mexp_pkg and the core; predicts each result with its own square-and-multiply.
module testbench;

    localparam int FW     = mexp_pkg::FIELD_W;
    localparam int OPND_W = mexp_pkg::MEXP_WIDTH;
    localparam int N_RANDOM = 270;
    // watchdog for 290 words plus sender gaps, with ample margin
    localparam int LIMIT_CYCLES = 2_500_000;

    typedef struct {
        logic [FW-1:0] base;
        logic [FW-1:0] exponent;
        logic [FW-1:0] modulus;
        bit            drain_first;  // hold off until no result is outstanding
    } t_mexp_word;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          start = 1'b0;
    logic [FW-1:0] i_base = '0;
    logic [FW-1:0] i_exponent = '0;
    logic [FW-1:0] i_modulus = '0;
    logic          busy;
    logic          o_valid;
    logic [FW-1:0] o_result;

    t_mexp_word    operand_q[$];
    logic [FW-1:0] pow_mod_q[$];
    int            fail_cnt = 0;
    int            cycle_cnt = 0;
    int            gap_left = 0;
    int            burst_left = 1;
    int            check_cnt = 0;
    int            word_total = 0;

    modular_exponentiation_core #(
        .WIDTH(OPND_W)
    ) u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_base    (i_base),
        .i_exponent(i_exponent),
        .i_modulus (i_modulus),
        .busy      (busy),
        .o_valid   (o_valid),
        .o_result  (o_result)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // base^exponent mod modulus on the low OPND_W bits, special cases first
    function automatic logic [FW-1:0] pow_mod(input logic [FW-1:0] b_in,
                                              input logic [FW-1:0] e_in,
                                              input logic [FW-1:0] m_in);
        logic [63:0] mask;
        logic [63:0] b;
        logic [63:0] e;
        logic [63:0] m;
        logic [63:0] acc;
        logic [63:0] sq;
        mask = (64'd1 << OPND_W) - 64'd1;
        b = {32'd0, b_in} & mask;
        e = {32'd0, e_in} & mask;
        m = {32'd0, m_in} & mask;
        if (b == 64'd0)
            return '0;
        if (e == 64'd0)
            return FW'(1);
        if (m == 64'd0)
            return '0;
        acc = 64'd1 % m;
        sq  = b % m;
        for (int i = 0; i < OPND_W; i++) begin
            if (e[i])
                acc = (acc * sq) % m;
            sq = (sq * sq) % m;
        end
        return acc[FW-1:0];
    endfunction

    task automatic add_word(input logic [FW-1:0] b, input logic [FW-1:0] e,
                            input logic [FW-1:0] m, input bit drain);
        t_mexp_word w;
        w.base = b;
        w.exponent = e;
        w.modulus = m;
        w.drain_first = drain;
        operand_q.push_back(w);
    endtask

    task automatic report_mismatch(input string what, input logic [FW-1:0] want,
                                   input logic [FW-1:0] got);
        fail_cnt++;
        if (fail_cnt <= 10)
            $display("mismatch (%s) at cycle %0d: expected %h, got %h",
                     what, cycle_cnt, want, got);
    endtask

    // driver: start stays up until taken; bursts of words with random gaps
    always @(posedge i_clk) begin
        t_mexp_word w;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy)
                pow_mod_q.push_back(pow_mod(i_base, i_exponent, i_modulus));
            if (!start || !busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (operand_q.size() == 0 ||
                             (operand_q[0].drain_first && pow_mod_q.size() != 0)) begin
                    start <= 1'b0;
                end else begin
                    w = operand_q.pop_front();
                    i_base     <= w.base;
                    i_exponent <= w.exponent;
                    i_modulus  <= w.modulus;
                    start      <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 8);
                        case ($urandom_range(0, 3))
                            0:       gap_left = 0;
                            1:       gap_left = $urandom_range(10, 60);
                            default: gap_left = $urandom_range(1, 4);
                        endcase
                    end
                end
            end
        end
    end

    // monitor: every strobed word must match the oldest prediction
    always @(posedge i_clk) begin
        logic [FW-1:0] want;
        if (i_rst_n && o_valid === 1'b1) begin
            check_cnt++;
            if (pow_mod_q.size() == 0) begin
                report_mismatch("unexpected word", 'x, o_result);
            end else begin
                want = pow_mod_q.pop_front();
                if (o_result !== want)
                    report_mismatch("result", want, o_result);
            end
        end
    end

    initial begin
        while (cycle_cnt < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin
        logic [FW-1:0] b;
        logic [FW-1:0] e;
        logic [FW-1:0] m;

        // zero base wins over zero exponent and zero modulus
        add_word(32'd0, 32'd0, 32'd1, 1'b0);
        add_word(32'd0, 32'd5, 32'd7, 1'b0);
        add_word(32'd0, 32'hFFFF_FFFF, 32'd0, 1'b0);
        // zero exponent gives 1 even for modulus 1
        add_word(32'd5, 32'd0, 32'd1, 1'b0);
        add_word(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 1'b0);
        // zero modulus is out of range but defined
        add_word(32'd7, 32'd3, 32'd0, 1'b0);
        add_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        add_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 1'b0);
        add_word(32'd1, 32'd1, 32'd1, 1'b0);
        add_word(32'd2, 32'd10, 32'd1000, 1'b0);
        add_word(32'd3, 32'd1, 32'd2, 1'b0);
        add_word(32'd1, 32'hFFFF_FFFF, 32'd2, 1'b0);
        add_word(32'hFFFF_FFFF, 32'd1, 32'h8000_0000, 1'b0);
        add_word(32'd123456789, 32'h8000_0000, 32'hFFFF_FFFB, 1'b0);
        add_word(32'd2, 32'd31, 32'hFFFF_FFFF, 1'b0);
        add_word(32'd17, 32'd3, 32'd17, 1'b0);
        add_word(32'd100, 32'd2, 32'd7, 1'b0);
        add_word(32'hDEAD_BEEF, 32'hAAAA_AAAA, 32'h8000_0001, 1'b0);
        add_word(32'h1234_5678, 32'h5555_5555, 32'h7FFF_FFFF, 1'b0);
        add_word(32'hFFFF_FFFE, 32'd2, 32'hFFFF_FFFF, 1'b0);

        for (int n = 0; n < N_RANDOM; n++) begin
            case ($urandom_range(0, 9))
                0:       b = '0;
                1:       b = 32'd1;
                2:       b = $urandom_range(2, 20);
                3:       b = 32'hFFFF_FFFF;
                default: b = $urandom;
            endcase
            case ($urandom_range(0, 9))
                0:          e = '0;
                1:          e = 32'hFFFF_FFFF;
                2, 3, 4:    e = $urandom >> $urandom_range(16, 31);
                default:    e = $urandom >> $urandom_range(0, 15);
            endcase
            case ($urandom_range(0, 9))
                0:       m = 32'd1;
                1:       m = $urandom_range(2, 16);
                2:       m = 32'hFFFF_FFFF;
                3:       m = {1'b1, 31'($urandom)};
                default: m = $urandom;
            endcase
            if (m == '0)
                m = 32'd1;
            // drain fully before the random part and once in its middle
            add_word(b, e, m, (n == 0) || (n == N_RANDOM / 2));
        end
        word_total = operand_q.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every queued word must come back as a strobed result
        while (check_cnt < word_total)
            @(posedge i_clk);
        // catch any stray strobe after the last word
        repeat (50) @(posedge i_clk);

        if (fail_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
